FILE: rtl/length_prefixed_deframer_core_assert.svh
// Assertion macros for the length-prefixed deframer.
// Included by the checker module; depends on nothing else.
`ifndef LENGTH_PREFIXED_DEFRAMER_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LPD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lpd_pkg.sv
// Shared types and constants for the length-prefixed deframer.
// Used by the framer, the output stage, the top level and the checker.
`default_nettype none

package lpd_pkg;

    localparam int unsigned PREFIX_BYTES = 4;
    localparam int unsigned CAP_W        = 13;
    localparam int unsigned FLEN_W       = 11;

    localparam logic [2:0]       FILL_FULL  = 3'd4;
    localparam logic [2:0]       FILL_SLIDE = 3'd3;
    localparam logic [CAP_W-1:0] CAP_RESET  = 13'd1024;

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_PASS = 3'b010,
        PH_SKIP = 3'b100
    } t_phase;

    typedef enum logic [1:0] {
        EV_BYTE   = 2'd0,
        EV_EMPTY  = 2'd1,
        EV_REJECT = 2'd2,
        EV_DROP   = 2'd3
    } t_event;

    typedef struct packed {
        t_event             event_res;
        logic [7:0]         payload_byte;
        logic               frame_last;
        logic [FLEN_W-1:0]  frame_length;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/lpd_framer.sv
// Framing state machine: prefix window, payload counters and capacity register.
// Computes at most one result per accepted transaction. Depends on lpd_pkg.
`default_nettype none

module lpd_framer #(
    parameter int unsigned BUFFER_BYTES = 2048
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire logic                        i_operation,
    input  wire logic [7:0]                  i_rx_byte,
    input  wire logic                        i_cfg_we,
    input  wire logic [lpd_pkg::CAP_W-1:0]   i_cfg_data,
    output logic                             o_res_valid,
    output lpd_pkg::t_result                 o_res
);

    localparam int unsigned MAX_LEN = BUFFER_BYTES - lpd_pkg::PREFIX_BYTES;
    localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1);

    lpd_pkg::t_phase              r_phase,  n_phase;
    // only the three newest bytes are ever read back
    logic [23:0]                  r_window, n_window;
    logic [2:0]                   r_fill,   n_fill;
    logic [LEN_W-1:0]             r_remain, n_remain;
    logic [LEN_W-1:0]             r_cur_len, n_cur_len;
    logic [lpd_pkg::CAP_W-1:0]    r_capacity;

    logic [31:0]                  window_sh;
    logic [2:0]                   fill_inc;
    logic [LEN_W-1:0]             plen;
    logic [31:0]                  cur_len32;
    logic                         oversize;
    logic                         last_byte;

    assign window_sh = {r_window, i_rx_byte};
    assign fill_inc  = (r_fill < lpd_pkg::FILL_FULL) ? r_fill + 3'd1 : r_fill;
    assign plen      = window_sh[LEN_W-1:0];
    assign cur_len32 = 32'(r_cur_len);
    assign oversize  = (32'(plen) + 32'd1) > 32'(r_capacity);
    assign last_byte = (r_remain <= LEN_W'(1));

    always_comb begin
        n_phase     = r_phase;
        n_window    = r_window;
        n_fill      = r_fill;
        n_remain    = r_remain;
        n_cur_len   = r_cur_len;
        o_res_valid = 1'b0;
        o_res       = '{event_res: lpd_pkg::EV_BYTE, payload_byte: 8'd0,
                        frame_last: 1'b0, frame_length: '0};

        if (i_accept) begin
            if (i_operation) begin
                // disconnect: drop all framing state, no result
                n_phase   = lpd_pkg::PH_HUNT;
                n_window  = '0;
                n_fill    = '0;
                n_remain  = '0;
                n_cur_len = '0;
            end else begin
                case (r_phase)
                    lpd_pkg::PH_PASS: begin
                        o_res_valid        = 1'b1;
                        o_res.payload_byte = i_rx_byte;
                        o_res.frame_last   = last_byte;
                        o_res.frame_length = cur_len32[lpd_pkg::FLEN_W-1:0];
                        if (last_byte) begin
                            n_phase   = lpd_pkg::PH_HUNT;
                            n_remain  = '0;
                            n_cur_len = '0;
                        end else begin
                            n_remain = r_remain - LEN_W'(1);
                        end
                    end
                    lpd_pkg::PH_SKIP: begin
                        if (last_byte) begin
                            o_res_valid        = 1'b1;
                            o_res.event_res    = lpd_pkg::EV_DROP;
                            o_res.frame_length = cur_len32[lpd_pkg::FLEN_W-1:0];
                            n_phase   = lpd_pkg::PH_HUNT;
                            n_remain  = '0;
                            n_cur_len = '0;
                        end else begin
                            n_remain = r_remain - LEN_W'(1);
                        end
                    end
                    lpd_pkg::PH_HUNT: begin
                        n_window = window_sh[23:0];
                        n_fill   = fill_inc;
                        if (fill_inc == lpd_pkg::FILL_FULL) begin
                            if (window_sh > 32'(MAX_LEN)) begin
                                // slide by one byte to resync
                                o_res_valid     = 1'b1;
                                o_res.event_res = lpd_pkg::EV_REJECT;
                                n_window        = window_sh[23:0];
                                n_fill          = lpd_pkg::FILL_SLIDE;
                            end else begin
                                n_window  = '0;
                                n_fill    = '0;
                                n_cur_len = plen;
                                n_remain  = plen;
                                if (plen == '0) begin
                                    o_res_valid     = 1'b1;
                                    o_res.event_res = oversize ? lpd_pkg::EV_DROP
                                                               : lpd_pkg::EV_EMPTY;
                                    n_cur_len       = '0;
                                    n_remain        = '0;
                                end else if (oversize) begin
                                    n_phase = lpd_pkg::PH_SKIP;
                                end else begin
                                    n_phase = lpd_pkg::PH_PASS;
                                end
                            end
                        end
                    end
                    default: begin
                        n_phase   = lpd_pkg::PH_HUNT;
                        n_window  = '0;
                        n_fill    = '0;
                        n_remain  = '0;
                        n_cur_len = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= lpd_pkg::PH_HUNT;
            r_window   <= '0;
            r_fill     <= '0;
            r_remain   <= '0;
            r_cur_len  <= '0;
            r_capacity <= lpd_pkg::CAP_RESET;
        end else begin
            r_phase   <= n_phase;
            r_window  <= n_window;
            r_fill    <= n_fill;
            r_remain  <= n_remain;
            r_cur_len <= n_cur_len;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lpd_out_reg.sv
// Output holding register for result transactions.
// Loads a new result whenever it is empty or being drained. Depends on lpd_pkg.
`default_nettype none

module lpd_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_res_valid,
    input  wire lpd_pkg::t_result  i_res,
    input  wire logic              i_out_ready,
    output logic                   o_load_en,
    output logic                   o_out_valid,
    output lpd_pkg::t_result       o_res
);

    logic             r_valid;
    lpd_pkg::t_result r_res;

    assign o_load_en   = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load_en) begin
            r_valid <= i_res_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (o_load_en && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/length_prefixed_deframer_core.sv
// Length-prefixed deframer, top level: framer plus output register.
// Depends on lpd_pkg, lpd_framer and lpd_out_reg.
//
// Takes one received byte per transaction and recovers frames that start with a
// 4-byte big-endian length. A new transaction is accepted every cycle while
// o_in_ready is high, and its result, if any (payload byte, empty frame,
// rejected prefix or dropped frame), appears in the output register on the
// next cycle. o_in_ready is low only while that register holds a result that
// has not been taken, so throughput is set by the consumer's i_out_ready.
// Lengths above BUFFER_BYTES - 4 are rejected and the prefix window slides by
// one byte; payloads needing length plus one bytes beyond the capacity
// register are skipped and reported as one drop.
`default_nettype none

module length_prefixed_deframer_core #(
    parameter int unsigned BUFFER_BYTES = 2048
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_operation,
    input  wire logic [7:0]                  i_rx_byte,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [1:0]                       o_event_res,
    output logic [7:0]                       o_payload_byte,
    output logic                             o_frame_last,
    output logic [lpd_pkg::FLEN_W-1:0]       o_frame_length,
    input  wire logic                        i_cfg_we,
    input  wire logic [lpd_pkg::CAP_W-1:0]   i_cfg_data
);

    logic             accept;
    logic             load_en;
    logic             res_valid;
    lpd_pkg::t_result res;
    lpd_pkg::t_result out_res;

    assign o_in_ready = load_en;
    assign accept     = i_in_valid && load_en;

    lpd_framer #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_operation (i_operation),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lpd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_out_ready (i_out_ready),
        .o_load_en   (load_en),
        .o_out_valid (o_out_valid),
        .o_res       (out_res)
    );

    assign o_event_res    = out_res.event_res;
    assign o_payload_byte = out_res.payload_byte;
    assign o_frame_last   = out_res.frame_last;
    assign o_frame_length = out_res.frame_length;

endmodule

`default_nettype wire

FILE: rtl/lpd_checker.sv
// Port-level checker for the length-prefixed deframer, bound to the top level.
// Depends on lpd_pkg and length_prefixed_deframer_core_assert.svh.
`default_nettype none

`include "length_prefixed_deframer_core_assert.svh"

module lpd_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        o_in_ready,
    input  wire logic                        o_out_valid,
    input  wire logic                        i_out_ready,
    input  wire logic [1:0]                  o_event_res,
    input  wire logic [7:0]                  o_payload_byte,
    input  wire logic                        o_frame_last,
    input  wire logic [lpd_pkg::FLEN_W-1:0]  o_frame_length
);

    `LPD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_event_res) && $stable(o_payload_byte)
            && $stable(o_frame_last) && $stable(o_frame_length),
        "stalled result transaction changed")
    `LPD_ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n,
        !o_out_valid, o_in_ready,
        "input stalled with empty output register")
    `LPD_ASSERT_IMPL(a_last_only_bytes, i_clk, i_rst_n,
        o_out_valid && o_frame_last, o_event_res == lpd_pkg::EV_BYTE,
        "frame_last set on a non-byte event")
    `LPD_ASSERT_IMPL(a_byte_zero, i_clk, i_rst_n,
        o_out_valid && (o_event_res != lpd_pkg::EV_BYTE), o_payload_byte == 8'd0,
        "payload byte set on a non-byte event")
    `LPD_ASSERT_IMPL(a_reject_len, i_clk, i_rst_n,
        o_out_valid && (o_event_res == lpd_pkg::EV_REJECT
            || o_event_res == lpd_pkg::EV_EMPTY),
        o_frame_length == '0,
        "non-zero length on reject or empty event")

endmodule

bind length_prefixed_deframer_core lpd_checker u_lpd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_event_res    (o_event_res),
    .o_payload_byte (o_payload_byte),
    .o_frame_last   (o_frame_last),
    .o_frame_length (o_frame_length)
);

`default_nettype wire

FILE: test/lpd_deframe_checker.sv
`timescale 1ns / 1ps
// Checker for the length-prefixed deframer: tracks the framing state from the
// byte transactions and capacity writes, and compares every result taken.
// Depends on lpd_pkg; hands its error count and backlog to the testbench top.
module lpd_deframe_checker #(
    parameter int unsigned BUFFER_BYTES = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_operation,
    input  logic [7:0]                    i_rx_byte,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [1:0]                    i_event_res,
    input  logic [7:0]                    i_payload_byte,
    input  logic                          i_frame_last,
    input  logic [lpd_pkg::FLEN_W-1:0]    i_frame_length,
    input  logic                          i_cfg_we,
    input  logic [lpd_pkg::CAP_W-1:0]     i_cfg_data,
    output int                            o_errors,
    output int                            o_outstanding
);

    logic [31:0]               prefix_win;
    logic [2:0]                win_fill;
    lpd_pkg::t_phase           frame_phase;
    int unsigned               bytes_left;
    int unsigned               frame_len;
    logic [lpd_pkg::CAP_W-1:0] capacity;
    lpd_pkg::t_result          expected_q[$];
    int                        errors = 0;

    task automatic restart_hunt();
        prefix_win  = '0;
        win_fill    = '0;
        frame_phase = lpd_pkg::PH_HUNT;
        bytes_left  = 0;
        frame_len   = 0;
    endtask

    // Advance the framing state by one transaction and queue its result, if any.
    task automatic predict_byte(input logic op, input logic [7:0] rx);
        lpd_pkg::t_result res;
        bit               produced;
        int unsigned      plen;
        res      = '0;
        produced = 1'b0;
        if (op) begin
            restart_hunt();
        end else begin
            case (frame_phase)
                lpd_pkg::PH_PASS: begin
                    res.event_res    = lpd_pkg::EV_BYTE;
                    res.payload_byte = rx;
                    res.frame_last   = (bytes_left <= 1);
                    res.frame_length = frame_len[lpd_pkg::FLEN_W-1:0];
                    produced         = 1'b1;
                    if (bytes_left <= 1) restart_hunt();
                    else bytes_left--;
                end
                lpd_pkg::PH_SKIP: begin
                    if (bytes_left <= 1) begin
                        res.event_res    = lpd_pkg::EV_DROP;
                        res.frame_length = frame_len[lpd_pkg::FLEN_W-1:0];
                        produced         = 1'b1;
                        restart_hunt();
                    end else begin
                        bytes_left--;
                    end
                end
                default: begin
                    prefix_win = {prefix_win[23:0], rx};
                    if (win_fill < lpd_pkg::FILL_FULL) win_fill++;
                    if (win_fill == lpd_pkg::FILL_FULL) begin
                        plen = prefix_win;
                        if (plen > BUFFER_BYTES - lpd_pkg::PREFIX_BYTES) begin
                            // slide by one byte: keep the three newest
                            prefix_win[31:24] = 8'd0;
                            win_fill          = lpd_pkg::FILL_SLIDE;
                            res.event_res     = lpd_pkg::EV_REJECT;
                            produced          = 1'b1;
                        end else if (plen + 1 > capacity) begin
                            if (plen == 0) begin
                                res.event_res = lpd_pkg::EV_DROP;
                                produced      = 1'b1;
                                restart_hunt();
                            end else begin
                                prefix_win  = '0;
                                win_fill    = '0;
                                frame_len   = plen;
                                bytes_left  = plen;
                                frame_phase = lpd_pkg::PH_SKIP;
                            end
                        end else if (plen == 0) begin
                            res.event_res = lpd_pkg::EV_EMPTY;
                            produced      = 1'b1;
                            restart_hunt();
                        end else begin
                            prefix_win  = '0;
                            win_fill    = '0;
                            frame_len   = plen;
                            bytes_left  = plen;
                            frame_phase = lpd_pkg::PH_PASS;
                        end
                    end
                end
            endcase
        end
        if (produced) expected_q.push_back(res);
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    task automatic check_result();
        lpd_pkg::t_result exp_r;
        if (expected_q.size() == 0) begin
            $error("result with nothing expected: event_res %0d", i_event_res);
            errors++;
        end else begin
            exp_r = expected_q.pop_front();
            compare_field("event_res", 32'(exp_r.event_res), 32'(i_event_res));
            compare_field("payload_byte", 32'(exp_r.payload_byte), 32'(i_payload_byte));
            compare_field("frame_last", 32'(exp_r.frame_last), 32'(i_frame_last));
            compare_field("frame_length", 32'(exp_r.frame_length), 32'(i_frame_length));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            capacity = lpd_pkg::CAP_RESET;
            restart_hunt();
            expected_q.delete();
        end else begin
            // a result never stems from the transaction taken at the same edge
            if (i_out_valid && i_out_ready) check_result();
            if (i_cfg_we) capacity = i_cfg_data;
            if (i_in_valid && i_in_ready) predict_byte(i_operation, i_rx_byte);
        end
        o_outstanding <= expected_q.size();
        o_errors      <= errors;
    end

endmodule

FILE: test/tb_length_prefixed_deframer_core.sv
`timescale 1ns / 1ps
// Testbench top for length_prefixed_deframer_core: builds byte streams of
// frames, resyncs and disconnects over several capacities, and gives the verdict.
// Depends on lpd_pkg, the block and lpd_deframe_checker.
module tb_length_prefixed_deframer_core;

    localparam int unsigned BUF_BYTES = 2048;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic                         i_operation = 1'b0;
    logic [7:0]                   i_rx_byte = 8'd0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic [1:0]                   o_event_res;
    logic [7:0]                   o_payload_byte;
    logic                         o_frame_last;
    logic [lpd_pkg::FLEN_W-1:0]   o_frame_length;
    logic                         i_cfg_we = 1'b0;
    logic [lpd_pkg::CAP_W-1:0]    i_cfg_data = '0;

    int                  errors;
    int                  outstanding;
    logic [8:0]          stim_q[$];   // {disconnect, byte}
    bit                  no_gaps = 1'b0;

    length_prefixed_deframer_core #(
        .BUFFER_BYTES (BUF_BYTES)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_res    (o_event_res),
        .o_payload_byte (o_payload_byte),
        .o_frame_last   (o_frame_last),
        .o_frame_length (o_frame_length),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    lpd_deframe_checker #(
        .BUFFER_BYTES (BUF_BYTES)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_rx_byte      (i_rx_byte),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_event_res    (o_event_res),
        .i_payload_byte (o_payload_byte),
        .i_frame_last   (o_frame_last),
        .i_frame_length (o_frame_length),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_errors       (errors),
        .o_outstanding  (outstanding)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Mostly no pause, some short ones, a few long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Receiver: runs of ready, now and then very long, broken by stalls.
    initial begin
        int run_len;
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 12);
            i_out_ready <= 1'b1;
            repeat (run_len) @(posedge i_clk);
            stall = gap_len();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    task automatic push_byte(input logic [7:0] value);
        stim_q.push_back({1'b0, value});
    endtask

    task automatic push_rand_byte(input int unsigned lo, input int unsigned hi);
        push_byte(8'($urandom_range(lo, hi)));
    endtask

    task automatic push_disconnect();
        stim_q.push_back({1'b1, 8'($urandom_range(0, 255))});
    endtask

    task automatic push_prefix(input int unsigned len);
        push_byte(len[31:24]);
        push_byte(len[23:16]);
        push_byte(len[15:8]);
        push_byte(len[7:0]);
    endtask

    task automatic push_frame(input int unsigned len);
        push_prefix(len);
        repeat (len) push_rand_byte(0, 255);
    endtask

    task automatic send_all();
        logic [8:0] item;
        int         gap;
        while (stim_q.size() > 0) begin
            item = stim_q.pop_front();
            gap  = no_gaps ? 0 : gap_len();
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_in_valid  <= 1'b1;
            i_operation <= item[8];
            i_rx_byte   <= item[7:0];
            @(posedge i_clk);
            while (!o_in_ready) @(posedge i_clk);
        end
        i_in_valid <= 1'b0;
    endtask

    // Hold until every expected result has been taken, plus a margin.
    task automatic drain(input int margin);
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (margin) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [lpd_pkg::CAP_W-1:0] value);
        drain(4);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        int unsigned phase_caps[9];
        int unsigned cap;
        int unsigned len;
        int unsigned kind;
        int unsigned cut;
        int          p;

        phase_caps = '{1, 17, 8191, 2, 4096, 0, 1024, 2045, 300};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset capacity: one-byte frame, empty frame,
        // reject then resync, length just over the buffer, disconnects.
        push_frame(1);
        push_frame(0);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h02);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_prefix(BUF_BYTES - lpd_pkg::PREFIX_BYTES + 1);
        push_disconnect();
        push_prefix(3);
        push_byte(8'hA5);
        push_disconnect();
        push_frame(0);
        send_all();

        // Capacity zero: zero length dropped at once, every frame skipped.
        set_capacity('0);
        push_frame(0);
        push_frame(2);
        push_prefix(3);
        push_byte(8'h5A);
        push_disconnect();
        send_all();

        for (p = 0; p < 10; p++) begin
            cap = (p == 9) ? $urandom_range(3, 4096) : phase_caps[p];
            set_capacity(cap[lpd_pkg::CAP_W-1:0]);
            no_gaps = ($urandom_range(0, 3) == 0);
            while (stim_q.size() < 160) begin
                kind = $urandom_range(0, 99);
                if (kind < 55) begin
                    if (cap >= 1 && cap <= 300 && $urandom_range(0, 4) == 0)
                        len = cap - $urandom_range(0, 1);   // either side of the limit
                    else if ($urandom_range(0, 4) == 0)
                        len = $urandom_range(13, 60);
                    else
                        len = $urandom_range(0, 12);
                    push_frame(len);
                end else if (kind < 65) begin
                    // rejected prefix whose low bytes resync onto a short frame
                    push_rand_byte(1, 255);
                    push_byte(8'h00);
                    push_byte(8'h00);
                    push_byte(8'h00);
                    len = $urandom_range(0, 12);
                    push_byte(len[7:0]);
                    repeat (len) push_rand_byte(0, 255);
                end else if (kind < 75) begin
                    repeat ($urandom_range(1, 8)) push_rand_byte(0, 255);
                    push_disconnect();
                end else if (kind < 85) begin
                    len = $urandom_range(1, 20);
                    cut = $urandom_range(0, len - 1);
                    push_prefix(len);
                    repeat (cut) push_rand_byte(0, 255);
                    push_disconnect();
                end else if (kind < 92) begin
                    push_byte(8'h00);
                    push_byte(8'h00);
                    if ($urandom_range(0, 1) == 0) begin
                        push_byte(8'h07);
                        push_rand_byte(8'hFD, 8'hFF);
                    end else begin
                        push_rand_byte(8, 255);
                        push_rand_byte(0, 255);
                    end
                    push_disconnect();
                end else begin
                    push_disconnect();
                end
            end
            // largest length the buffer takes, at the exact capacity boundary;
            // pass a few of its bytes, then cut it short
            if (cap == BUF_BYTES - lpd_pkg::PREFIX_BYTES + 1) begin
                push_prefix(BUF_BYTES - lpd_pkg::PREFIX_BYTES);
                repeat (5) push_rand_byte(0, 255);
            end
            push_disconnect();
            send_all();
        end

        drain(16);
        if (errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: length_prefixed_deframer_core.f
+incdir+rtl
rtl/lpd_pkg.sv
rtl/lpd_framer.sv
rtl/lpd_out_reg.sv
rtl/length_prefixed_deframer_core.sv
rtl/lpd_checker.sv
test/lpd_deframe_checker.sv
test/tb_length_prefixed_deframer_core.sv
